// ===== rtl/sio_pkg.sv =====
// ----------------------------------------------------------------------------
// sio_pkg: shared types and constants of the sound I/O page
// Register offsets, the decoded operation codes and the queue item format.
// ----------------------------------------------------------------------------
package sio_pkg;

	// register offsets within the I/O page
	localparam logic [7:0] OFF_SHIFT0   = 8'h02;
	localparam logic [7:0] OFF_SHIFT1   = 8'h03;
	localparam logic [7:0] OFF_ZERO     = 8'h06;
	localparam logic [7:0] OFF_SHCTRL   = 8'h07;
	localparam logic [7:0] OFF_MAILBOX  = 8'h0A;
	localparam logic [7:0] OFF_IRQEN    = 8'h10;
	localparam logic [7:0] OFF_IRQSRC   = 8'h11;
	localparam logic [7:0] OFF_CHIPIDX  = 8'h20;
	localparam logic [7:0] OFF_CHIPDATA = 8'h22;

	// source bit set by the host mailbox knock
	localparam int KNOCK_BIT = 5;

	// pads and their shift control bit groups
	localparam int NUM_PADS = 2;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// request modes
	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_IRQ   = 2'd2,
		MODE_KNOCK = 2'd3
	} mode_t;

	// decoded operations
	typedef enum logic [3:0] {
		OP_RAM,
		OP_RD_SHIFT0,
		OP_RD_SHIFT1,
		OP_RD_ZERO,
		OP_RD_IRQEN,
		OP_RD_IRQSRC,
		OP_CHIP_DATA,
		OP_WR_SHCTRL,
		OP_WR_MAILBOX,
		OP_WR_IRQEN,
		OP_WR_CHIPIDX,
		OP_IRQ_LINE,
		OP_KNOCK
	} op_t;

	typedef logic [NUM_PADS-1:0][15:0] pads_t;

	// one decoded request as it waits in the queue
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		pads_t      pads;
		logic [2:0] irq_bit;
		logic       irq_level;
	} item_t;

endpackage

// ===== rtl/sio_if.sv =====
// ----------------------------------------------------------------------------
// sio_if: request and response channels of the sound I/O page
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface sio_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  reg_offset;
	logic [7:0]  write_data;
	logic [15:0] pad0_buttons;
	logic [15:0] pad1_buttons;
	logic [2:0]  irq_bit;
	logic        irq_level;

	modport source (output valid, mode, reg_offset, write_data, pad0_buttons,
		pad1_buttons, irq_bit, irq_level, input ready);
	modport sink (input valid, mode, reg_offset, write_data, pad0_buttons,
		pad1_buttons, irq_bit, irq_level, output ready);
endinterface

interface sio_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       ram_access;
	logic       chip_access;
	logic [7:0] chip_reg_index;
	logic       host_irq_pulse;
	logic       sound_irq;

	modport source (output valid, read_data, ram_access, chip_access,
		chip_reg_index, host_irq_pulse, sound_irq, input ready);
	modport sink (input valid, read_data, ram_access, chip_access,
		chip_reg_index, host_irq_pulse, sound_irq, output ready);
endinterface

// ===== rtl/sio_front.sv =====
// ----------------------------------------------------------------------------
// sio_front: request decoder
// Accepts requests and turns mode and offset into one operation code.
// ----------------------------------------------------------------------------
module sio_front (
	sio_req_if.sink        req,
	output logic           push_valid,
	output sio_pkg::item_t push_item,
	input  logic           queue_full
);
	import sio_pkg::*;

	sio_pkg::op_t op;

	// accept whenever the queue has room
	assign req.ready  = !queue_full;
	assign push_valid = req.valid;

	// classify by mode and offset
	always_comb begin
		op = OP_RAM;
		unique case (mode_t'(req.mode))
			MODE_READ: begin
				case (req.reg_offset)
					OFF_SHIFT0:   op = OP_RD_SHIFT0;
					OFF_SHIFT1:   op = OP_RD_SHIFT1;
					OFF_ZERO:     op = OP_RD_ZERO;
					OFF_IRQEN:    op = OP_RD_IRQEN;
					OFF_IRQSRC:   op = OP_RD_IRQSRC;
					OFF_CHIPIDX:  op = OP_RD_ZERO;
					OFF_CHIPDATA: op = OP_CHIP_DATA;
					default:      op = OP_RAM;
				endcase
			end
			MODE_WRITE: begin
				case (req.reg_offset)
					OFF_SHCTRL:   op = OP_WR_SHCTRL;
					OFF_MAILBOX:  op = OP_WR_MAILBOX;
					OFF_IRQEN:    op = OP_WR_IRQEN;
					OFF_CHIPIDX:  op = OP_WR_CHIPIDX;
					OFF_CHIPDATA: op = OP_CHIP_DATA;
					default:      op = OP_RAM;
				endcase
			end
			MODE_IRQ:   op = OP_IRQ_LINE;
			MODE_KNOCK: op = OP_KNOCK;
			default:    op = OP_RAM;
		endcase
	end

	// pack the decoded request
	always_comb begin
		push_item.op        = op;
		push_item.data      = req.write_data;
		push_item.pads[0]   = req.pad0_buttons;
		push_item.pads[1]   = req.pad1_buttons;
		push_item.irq_bit   = req.irq_bit;
		push_item.irq_level = req.irq_level;
	end

endmodule

// ===== rtl/sio_queue.sv =====
// ----------------------------------------------------------------------------
// sio_queue: decoupling queue
// Small register FIFO between decoder and execution so each side stalls alone.
// ----------------------------------------------------------------------------
module sio_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  sio_pkg::item_t push_item,
	output logic           full,
	output logic           pop_valid,
	output sio_pkg::item_t pop_item,
	input  logic           pop_ready
);
	import sio_pkg::*;

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];
	assign push      = push_valid && !full;
	assign pop       = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

endmodule

// ===== rtl/sio_back.sv =====
// ----------------------------------------------------------------------------
// sio_back: execution and register file
// Applies decoded requests to the page registers and holds the response.
// ----------------------------------------------------------------------------
module sio_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  sio_pkg::item_t pop_item,
	output logic           pop_ready,
	sio_rsp_if.source      rsp
);
	import sio_pkg::*;

	// page registers
	logic [7:0]  shctrl_q;
	logic [7:0]  shift_q [NUM_PADS];
	logic [15:0] latch_q [NUM_PADS];
	logic [7:0]  irq_en_q;
	logic [7:0]  irq_src_q;
	logic [7:0]  chip_idx_q;

	logic [7:0]  shctrl_n;
	logic [7:0]  shift_n [NUM_PADS];
	logic [15:0] latch_n [NUM_PADS];
	logic [7:0]  irq_en_n;
	logic [7:0]  irq_src_n;
	logic [7:0]  chip_idx_n;
	logic [7:0]  fell;

	// response register
	logic        rsp_valid_q;
	logic [7:0]  read_data_q;
	logic        ram_q;
	logic        chip_q;
	logic [7:0]  chip_reg_index_q;
	logic        host_q;
	logic        sound_irq_q;

	logic [7:0]  rd;
	logic        ram;
	logic        chip;
	logic        host;
	logic        take;

	assign pop_ready = !rsp_valid_q || rsp.ready;
	assign take      = pop_valid && pop_ready;
	assign fell      = shctrl_q & ~pop_item.data;

	// execute one request
	always_comb begin
		shctrl_n   = shctrl_q;
		shift_n    = shift_q;
		latch_n    = latch_q;
		irq_en_n   = irq_en_q;
		irq_src_n  = irq_src_q;
		chip_idx_n = chip_idx_q;
		rd         = '0;
		ram        = 1'b0;
		chip       = 1'b0;
		host       = 1'b0;
		unique case (pop_item.op)
			OP_RAM:        ram = 1'b1;
			OP_RD_SHIFT0:  rd = shift_q[0];
			OP_RD_SHIFT1:  rd = shift_q[1];
			OP_RD_ZERO:    rd = '0;
			OP_RD_IRQEN:   rd = irq_en_q;
			OP_RD_IRQSRC: begin
				rd        = irq_src_q;
				irq_src_n = '0;
			end
			OP_CHIP_DATA:  chip = 1'b1;
			OP_WR_SHCTRL: begin
				shctrl_n = pop_item.data;
				// per pad: latch, then shift, then clear
				for (int p = 0; p < NUM_PADS; p++) begin
					if (fell[p]) begin
						latch_n[p] = pop_item.pads[p];
					end
					if (fell[p + NUM_PADS]) begin
						shift_n[p] = {shift_n[p][6:0], latch_n[p][15]};
						latch_n[p] = {latch_n[p][14:0], 1'b0};
					end
					if (fell[p + 2 * NUM_PADS]) begin
						shift_n[p] = '0;
					end
				end
			end
			OP_WR_MAILBOX: begin
				host = 1'b1;
				ram  = 1'b1;
			end
			OP_WR_IRQEN:   irq_en_n = pop_item.data;
			OP_WR_CHIPIDX: chip_idx_n = pop_item.data;
			OP_IRQ_LINE:   irq_src_n[pop_item.irq_bit] = pop_item.irq_level;
			OP_KNOCK:      irq_src_n[KNOCK_BIT] = 1'b1;
			default:       ram = 1'b0;
		endcase
	end

	// register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shctrl_q   <= '0;
			shift_q    <= '{default: '0};
			latch_q    <= '{default: '0};
			irq_en_q   <= '0;
			irq_src_q  <= '0;
			chip_idx_q <= '0;
		end else if (take) begin
			shctrl_q   <= shctrl_n;
			shift_q    <= shift_n;
			latch_q    <= latch_n;
			irq_en_q   <= irq_en_n;
			irq_src_q  <= irq_src_n;
			chip_idx_q <= chip_idx_n;
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pop_ready) begin
			rsp_valid_q <= pop_valid;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (take) begin
			read_data_q      <= rd;
			ram_q            <= ram;
			chip_q           <= chip;
			chip_reg_index_q <= chip_idx_n;
			host_q           <= host;
			sound_irq_q      <= |(irq_en_n & irq_src_n);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_data      = read_data_q;
	assign rsp.ram_access     = ram_q;
	assign rsp.chip_access    = chip_q;
	assign rsp.chip_reg_index = chip_reg_index_q;
	assign rsp.host_irq_pulse = host_q;
	assign rsp.sound_irq      = sound_irq_q;

	a_irq_level: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (sound_irq_q == |(irq_en_q & irq_src_q)))
		else $error("sound irq does not match enable and sources");

	a_src_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && pop_item.op == OP_RD_IRQSRC) |=> (irq_src_q == '0))
		else $error("source register not cleared by read");

	a_mailbox_ram: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && host_q) |-> (ram_q && !chip_q && read_data_q == '0))
		else $error("mailbox response not stored in ram");

endmodule

// ===== rtl/sound_io_pad_shift_and_irq_regs_unit.sv =====
// A taken request is written into the queue, then executed into the response
// register, from which its response is taken.
// Throughput: one request per cycle as long as responses are taken as they come.
// A stalled response holds the register file; the two-entry queue fills up and then
// the input stalls until the response is taken.
// Reset (arst_n low) clears all page registers, the queue and the response valid.
// ----------------------------------------------------------------------------
// sound_io_pad_shift_and_irq_regs_unit: sound processor I/O page
// Pad shift registers, interrupt enable and sources, chip index and mailbox.
// ----------------------------------------------------------------------------
module sound_io_pad_shift_and_irq_regs_unit (
	input  logic      clk,
	input  logic      arst_n,
	sio_req_if.sink   req,
	sio_rsp_if.source rsp
);
	import sio_pkg::*;

	logic  push_valid;
	item_t push_item;
	logic  queue_full;
	logic  pop_valid;
	item_t pop_item;
	logic  pop_ready;

	// decode
	sio_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	// decouple
	sio_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.full       (queue_full),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// execute
	sio_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule

// ===== verif/sound_io_pad_shift_and_irq_regs_unit_test.sv =====
// ----------------------------------------------------------------------------
// sound_io_pad_shift_and_irq_regs_unit_test: self-checking bench of the I/O page
// Drives byte reads and writes, irq line changes and mailbox knocks through the
// request channel, keeps its own copy of the page registers, and compares every
// response field by field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module sound_io_pad_shift_and_irq_regs_unit_test;
	import sio_pkg::*;

	localparam int REQUEST_COUNT = 1450;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int LONG_HOLD     = 80;

	// one request as driven on the request channel
	typedef struct packed {
		mode_t       mode;
		logic [7:0]  offset;
		logic [7:0]  data;
		logic [15:0] pad0;
		logic [15:0] pad1;
		logic [2:0]  irq_bit;
		logic        irq_level;
	} page_req_t;

	// one response as seen on the response channel
	typedef struct packed {
		logic [7:0] read_data;
		logic       ram;
		logic       chip;
		logic [7:0] chip_idx;
		logic       host;
		logic       irq;
	} page_rsp_t;

	typedef enum {
		PACE_STEADY,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	// page register mirror and the replies it still owes
	class page_scoreboard;
		logic [7:0]  shift_ctrl;
		logic [7:0]  shift_reg [2];
		logic [15:0] latch [2];
		logic [7:0]  irq_en;
		logic [7:0]  irq_src;
		logic [7:0]  chip_idx;
		page_rsp_t   pending_replies [$];
		int          errors;

		function new();
			shift_ctrl = '0;
			shift_reg[0] = '0;
			shift_reg[1] = '0;
			latch[0] = '0;
			latch[1] = '0;
			irq_en = '0;
			irq_src = '0;
			chip_idx = '0;
			errors = 0;
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction

		function void note_request(page_req_t r);
			page_rsp_t   e;
			logic [7:0]  fell;
			logic [15:0] pads [2];
			e = '0;
			pads[0] = r.pad0;
			pads[1] = r.pad1;
			case (r.mode)
				MODE_READ: begin
					case (r.offset)
						OFF_SHIFT0: e.read_data = shift_reg[0];
						OFF_SHIFT1: e.read_data = shift_reg[1];
						OFF_ZERO, OFF_CHIPIDX: e.read_data = '0;
						OFF_IRQEN: e.read_data = irq_en;
						OFF_IRQSRC: begin
							e.read_data = irq_src;
							irq_src = '0;
						end
						OFF_CHIPDATA: e.chip = 1'b1;
						default: e.ram = 1'b1;
					endcase
				end
				MODE_WRITE: begin
					case (r.offset)
						OFF_SHCTRL: begin
							// falling bits: latch, then shift, then clear, pad 0 first
							fell = shift_ctrl & ~r.data;
							shift_ctrl = r.data;
							for (int p = 0; p < 2; p++) begin
								if (fell[p])
									latch[p] = pads[p];
								if (fell[p + 2]) begin
									shift_reg[p] = {shift_reg[p][6:0], latch[p][15]};
									latch[p] = latch[p] << 1;
								end
								if (fell[p + 4])
									shift_reg[p] = '0;
							end
						end
						OFF_MAILBOX: begin
							e.host = 1'b1;
							e.ram = 1'b1;
						end
						OFF_IRQEN: irq_en = r.data;
						OFF_CHIPIDX: chip_idx = r.data;
						OFF_CHIPDATA: e.chip = 1'b1;
						default: e.ram = 1'b1;
					endcase
				end
				MODE_IRQ: irq_src[r.irq_bit] = r.irq_level;
				default: irq_src[KNOCK_BIT] = 1'b1;
			endcase
			e.chip_idx = chip_idx;
			e.irq = |(irq_en & irq_src);
			pending_replies.push_back(e);
		endfunction

		function void check_reply(page_rsp_t got);
			page_rsp_t e;
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: response with none outstanding: rd=%h ram=%b chip=%b idx=%h host=%b irq=%b",
					$time, got.read_data, got.ram, got.chip, got.chip_idx, got.host, got.irq);
				return;
			end
			e = pending_replies.pop_front();
			if (got !== e) begin
				errors++;
				$display("%0t: expected rd=%h ram=%b chip=%b idx=%h host=%b irq=%b, got rd=%h ram=%b chip=%b idx=%h host=%b irq=%b",
					$time, e.read_data, e.ram, e.chip, e.chip_idx, e.host, e.irq,
					got.read_data, got.ram, got.chip, got.chip_idx, got.host, got.irq);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sio_req_if req_ch();
	sio_rsp_if rsp_ch();

	sound_io_pad_shift_and_irq_regs_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	page_scoreboard sb = new();

	int sent;
	int cycle_count;
	int idle_pct;
	int stall_pct;
	int hold_left;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// timeout
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// response ready, with random stalls and long hold-offs
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready = 1'b0;
			hold_left--;
		end else begin
			rsp_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_reply({rsp_ch.read_data, rsp_ch.ram_access, rsp_ch.chip_access,
				rsp_ch.chip_reg_index, rsp_ch.host_irq_pulse, rsp_ch.sound_irq});
	end

	task set_pace(pace_t p);
		case (p)
			PACE_STEADY: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			PACE_SENDER_IDLE: begin
				idle_pct = 78;
				stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				idle_pct = 0;
				stall_pct = 78;
			end
			default: begin
				idle_pct = 22;
				stall_pct = 22;
			end
		endcase
	endtask

	// offer one request from a falling edge until it is taken
	task send_request(page_req_t r);
		if ($urandom_range(99) < idle_pct) begin
			req_ch.valid = 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		req_ch.mode = r.mode;
		req_ch.reg_offset = r.offset;
		req_ch.write_data = r.data;
		req_ch.pad0_buttons = r.pad0;
		req_ch.pad1_buttons = r.pad1;
		req_ch.irq_bit = r.irq_bit;
		req_ch.irq_level = r.irq_level;
		req_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(r);
		sent++;
		@(negedge clk);
	endtask

	task send_op(mode_t m, logic [7:0] off, logic [7:0] d, logic [15:0] p0,
		logic [15:0] p1, logic [2:0] b, logic lvl);
		send_request({m, off, d, p0, p1, b, lvl});
	endtask

	// stop offering and wait for every owed response
	task wait_drained();
		req_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// pick an offset that decodes to a register, or sometimes any offset from OFF_SHIFT0 to just past OFF_CHIPDATA
	function logic [7:0] register_offset();
		case ($urandom_range(9))
			0: return OFF_SHIFT0;
			1: return OFF_SHIFT1;
			2: return OFF_ZERO;
			3: return OFF_SHCTRL;
			4: return OFF_MAILBOX;
			5: return OFF_IRQEN;
			6: return OFF_IRQSRC;
			7: return OFF_CHIPIDX;
			8: return OFF_CHIPDATA;
			default: return 8'($urandom_range(OFF_SHIFT0, OFF_CHIPDATA + 1));
		endcase
	endfunction

	function page_req_t random_request();
		page_req_t r;
		int pick;
		r.data = 8'($urandom);
		r.pad0 = 16'($urandom);
		r.pad1 = 16'($urandom);
		r.irq_bit = 3'($urandom);
		r.irq_level = 1'($urandom);
		r.offset = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 45) begin
			r.mode = $urandom_range(1) ? MODE_WRITE : MODE_READ;
			r.offset = register_offset();
		end else if (pick < 65) begin
			r.mode = $urandom_range(1) ? MODE_WRITE : MODE_READ;
		end else if (pick < 88) begin
			r.mode = MODE_IRQ;
		end else if (pick < 95) begin
			r.mode = MODE_KNOCK;
		end else begin
			r.mode = mode_t'($urandom_range(3));
		end
		return r;
	endfunction

	// well-formed pad readout: latch, clock one to ten bits, read back, maybe clear
	task pad_readout();
		logic [7:0] latch_bits;
		logic [7:0] clock_bits;
		logic [7:0] top;
		int shifts;
		latch_bits = 8'($urandom_range(1, 3));
		clock_bits = 8'($urandom_range(1, 3)) << 2;
		top = {2'($urandom), 6'h3F};
		shifts = $urandom_range(1, 10);
		send_op(MODE_WRITE, OFF_SHCTRL, top, 16'($urandom), 16'($urandom),
			3'($urandom), 1'($urandom));
		send_op(MODE_WRITE, OFF_SHCTRL, top & ~latch_bits, 16'($urandom),
			16'($urandom), 3'($urandom), 1'($urandom));
		repeat (shifts) begin
			send_op(MODE_WRITE, OFF_SHCTRL, top, 16'($urandom), 16'($urandom),
				3'($urandom), 1'($urandom));
			if ($urandom_range(99) < 15)
				send_request(random_request());
			send_op(MODE_WRITE, OFF_SHCTRL, top & ~clock_bits, 16'($urandom),
				16'($urandom), 3'($urandom), 1'($urandom));
		end
		send_op(MODE_READ, OFF_SHIFT0, 8'($urandom), 16'($urandom), 16'($urandom),
			3'($urandom), 1'($urandom));
		send_op(MODE_READ, OFF_SHIFT1, 8'($urandom), 16'($urandom), 16'($urandom),
			3'($urandom), 1'($urandom));
		if ($urandom_range(99) < 30) begin
			send_op(MODE_WRITE, OFF_SHCTRL, 8'hFF, 16'($urandom), 16'($urandom),
				3'($urandom), 1'($urandom));
			send_op(MODE_WRITE, OFF_SHCTRL, 8'h0F, 16'($urandom), 16'($urandom),
				3'($urandom), 1'($urandom));
		end
	endtask

	task random_until(int target);
		while (sent < target) begin
			if ($urandom_range(99) < 12)
				pad_readout();
			else
				send_request(random_request());
		end
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		sent = 0;
		hold_left = 0;
		idle_pct = 0;
		stall_pct = 0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_READ;
		req_ch.reg_offset = '0;
		req_ch.write_data = '0;
		req_ch.pad0_buttons = '0;
		req_ch.pad1_buttons = '0;
		req_ch.irq_bit = '0;
		req_ch.irq_level = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every register, field extremes, knock, mailbox, source clear
		set_pace(PACE_STEADY);
		send_op(MODE_READ, OFF_SHIFT0, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_SHCTRL, 8'hFF, 16'hFFFF, 16'h0000, 3'd7, 1'b1);
		send_op(MODE_WRITE, OFF_SHCTRL, 8'h00, 16'h8000, 16'hFFFF, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_SHCTRL, 8'h0F, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_SHCTRL, 8'h0C, 16'hFFFF, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_SHCTRL, 8'h0F, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_SHCTRL, 8'h03, 16'h0000, 16'hFFFF, 3'd0, 1'b0);
		send_op(MODE_READ, OFF_SHIFT0, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1);
		send_op(MODE_READ, OFF_SHIFT1, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_IRQEN, 8'hFF, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_IRQ, 8'h00, 8'h00, 16'h0000, 16'h0000, 3'd7, 1'b1);
		send_op(MODE_IRQ, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd0, 1'b0);
		send_op(MODE_KNOCK, 8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_READ, OFF_IRQEN, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_READ, OFF_IRQSRC, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_READ, OFF_IRQSRC, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_MAILBOX, 8'hA5, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_CHIPIDX, 8'hFF, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_READ, OFF_CHIPIDX, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_READ, OFF_CHIPDATA, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_CHIPDATA, 8'h5A, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_READ, OFF_ZERO, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_READ, 8'hFF, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, 8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 1'b0);
		send_op(MODE_WRITE, OFF_CHIPIDX, 8'h00, 16'h0000, 16'h0000, 3'd0, 1'b0);
		wait_drained();

		// random phases over the idling profiles
		set_pace(PACE_STEADY);
		random_until(300);
		set_pace(PACE_SENDER_IDLE);
		random_until(600);
		wait_drained();
		set_pace(PACE_RECEIVER_STALL);
		random_until(900);
		set_pace(PACE_BOTH);
		random_until(1150);
		wait_drained();

		// receiver holds off while requests keep coming, so the input backs up
		set_pace(PACE_STEADY);
		hold_left = LONG_HOLD;
		random_until(sent + 30);
		wait_drained();

		set_pace(PACE_BOTH);
		random_until(1300);
		set_pace(PACE_STEADY);
		random_until(REQUEST_COUNT);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
